/* rtl/core/rau_pkg.sv */
// Shared widths, operation codes and state types of the rational arithmetic unit.
// Uses nothing; every other file imports it.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int unsigned OPW = 16;           // operand width
  localparam int unsigned PW  = 2 * OPW;      // product and magnitude width
  localparam int unsigned NW  = PW + 1;       // result numerator width
  localparam int unsigned DW  = PW - 1;       // result denominator width
  localparam int unsigned CW  = $clog2(PW);   // step and shift counter width

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FORM,
    ST_REDUCE,
    ST_DONE
  } top_state_e;

  typedef enum logic [1:0] {
    RS_IDLE,
    RS_TWOS,
    RS_GCD,
    RS_DIV
  } red_state_e;
endpackage

/* rtl/core/rau_reduce.sv */
// Reduction engine: binary gcd of two positive magnitudes, then exact division of
// both by the gcd with two restoring dividers stepped together. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_reduce import rau_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] x_i,
  input  logic [PW-1:0] y_i,
  output logic          done_o,
  output logic [PW-1:0] qx_o,
  output logic [PW-1:0] qy_o
);
  red_state_e    state_q, state_d;
  logic [PW-1:0] x_q, x_d, y_q, y_d;
  logic [PW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [PW:0]   rx_q, rx_d, ry_q, ry_d;
  logic [PW-1:0] g_q, g_d;
  logic [CW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [PW:0]   shx, shy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RS_IDLE;
      done_q  <= 1'b0;
      k_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    dx_q <= dx_d;
    dy_q <= dy_d;
    rx_q <= rx_d;
    ry_q <= ry_d;
    g_q  <= g_d;
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    x_d = x_q; y_d = y_q; dx_d = dx_q; dy_d = dy_q;
    rx_d = rx_q; ry_d = ry_q; g_d = g_q;
    k_d = k_q; cnt_d = cnt_q;
    shx = {rx_q[PW-1:0], dx_q[PW-1]};
    shy = {ry_q[PW-1:0], dy_q[PW-1]};
    unique case (state_q)
      RS_IDLE: begin
        if (start_i) begin
          x_d = x_i; y_d = y_i; dx_d = x_i; dy_d = y_i;
          k_d = '0;
          state_d = RS_TWOS;
        end
      end
      RS_TWOS: begin
        // strip the common power of two
        if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end else begin
          state_d = RS_GCD;
        end
      end
      RS_GCD: begin
        priority if (x_q == '0) begin
          g_d = y_q << k_q;
          state_d = RS_DIV;
        end else if (y_q == '0) begin
          g_d = x_q << k_q;
          state_d = RS_DIV;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q >= y_q) begin
          x_d = x_q - y_q;
        end else begin
          y_d = y_q - x_q;
        end
        rx_d = '0; ry_d = '0; cnt_d = '0;
      end
      RS_DIV: begin
        // one quotient bit per cycle for both dividends
        if (shx >= {1'b0, g_q}) begin
          rx_d = shx - {1'b0, g_q};
          dx_d = {dx_q[PW-2:0], 1'b1};
        end else begin
          rx_d = shx;
          dx_d = {dx_q[PW-2:0], 1'b0};
        end
        if (shy >= {1'b0, g_q}) begin
          ry_d = shy - {1'b0, g_q};
          dy_d = {dy_q[PW-2:0], 1'b1};
        end else begin
          ry_d = shy;
          dy_d = {dy_q[PW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(PW - 1)) begin
          done_d  = 1'b1;
          state_d = RS_IDLE;
        end
      end
      default: state_d = RS_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign qx_o   = dx_q;
  assign qy_o   = dy_q;
endmodule

/* rtl/core/rational_arithmetic_unit.sv */
// Rational arithmetic unit: one item in flight; busy_o is high from the start transfer
// until the result strobe. The run time is set by the binary gcd loop (data dependent)
// plus a 32-step division by the gcd, after the passes through the shared multiplier.
// Error items strobe in the cycle after the start transfer and zero results after the
// multiplier passes and the form state. Reset clears the sequencer only.
// The result is shown for one cycle on res_valid_o and the receiver cannot stall it.
`timescale 1ns / 1ps
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            operation_i,
  input  logic signed [OPW-1:0] a_num_i,
  input  logic signed [OPW-1:0] a_den_i,
  input  logic signed [OPW-1:0] b_num_i,
  input  logic signed [OPW-1:0] b_den_i,
  output logic                  res_valid_o,
  output logic signed [NW-1:0]  res_num_o,
  output logic [DW-1:0]         res_den_o,
  output logic                  div_error_o
);
  top_state_e           state_q, state_d;
  logic [1:0]           idx_q, idx_d;
  op_e                  op_q;
  logic signed [OPW-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0] p_q [3];
  logic signed [OPW-1:0] m_a, m_b;
  logic signed [PW-1:0] prod;
  logic signed [NW-1:0] num_raw, num_fix;
  logic signed [PW-1:0] den_raw, den_fix;
  logic [PW-1:0]        mag;
  logic                 neg_q;
  logic                 red_start, red_done;
  logic [PW-1:0]        qx, qy;
  logic signed [NW-1:0] res_num_q;
  logic [DW-1:0]        res_den_q;
  logic                 err_q;
  logic                 in_err;

  // Reject zero denominators and division by a zero numerator up front.
  assign in_err = (a_den_i == '0) || (b_den_i == '0) ||
                  ((op_e'(operation_i) == OP_DIV) && (b_num_i == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    red_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          idx_d   = '0;
          state_d = in_err ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        // three passes through the one multiplier
        idx_d = idx_q + 1'b1;
        if (idx_q == 2'd2) state_d = ST_FORM;
      end
      ST_FORM: begin
        if (num_fix == '0) begin
          state_d = ST_DONE;
        end else begin
          red_start = 1'b1;
          state_d   = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (red_done) state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Operand select for the shared multiplier.
  always_comb begin
    m_a = an_q;
    m_b = bd_q;
    unique case (idx_q)
      2'd0: begin
        m_a = an_q;
        m_b = (op_q == OP_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        m_a = ad_q;
        m_b = ((op_q == OP_ADD) || (op_q == OP_SUB)) ? bn_q : ((op_q == OP_MUL) ? bd_q : bn_q);
        if ((op_q == OP_ADD) || (op_q == OP_SUB)) m_a = bn_q;
        if ((op_q == OP_ADD) || (op_q == OP_SUB)) m_b = ad_q;
      end
      default: begin
        m_a = ad_q;
        m_b = bd_q;
      end
    endcase
  end

  assign prod = m_a * m_b;

  // Combine the products into one fraction, then move the sign to the numerator.
  always_comb begin
    unique case (op_q)
      OP_ADD: begin
        num_raw = NW'(p_q[0]) + NW'(p_q[1]);
        den_raw = p_q[2];
      end
      OP_SUB: begin
        num_raw = NW'(p_q[0]) - NW'(p_q[1]);
        den_raw = p_q[2];
      end
      default: begin
        num_raw = NW'(p_q[0]);
        den_raw = p_q[1];
      end
    endcase
    num_fix = den_raw[PW-1] ? -num_raw : num_raw;
    den_fix = den_raw[PW-1] ? -den_raw : den_raw;
    mag     = num_fix[NW-1] ? PW'(-num_fix) : PW'(num_fix);
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start_i) begin
      op_q <= op_e'(operation_i);
      an_q <= a_num_i;
      ad_q <= a_den_i;
      bn_q <= b_num_i;
      bd_q <= b_den_i;
      // error result is 0/0
      res_num_q <= '0;
      res_den_q <= '0;
      err_q     <= in_err;
    end
    if (state_q == ST_MUL) p_q[idx_q] <= prod;
    if (state_q == ST_FORM) begin
      neg_q <= num_fix[NW-1];
      // zero result is 0/1
      res_num_q <= '0;
      res_den_q <= DW'(1);
      err_q     <= 1'b0;
    end
    if ((state_q == ST_REDUCE) && red_done) begin
      res_num_q <= neg_q ? -NW'(qx) : NW'(qx);
      res_den_q <= qy[DW-1:0];
    end
  end

  rau_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .x_i     (mag),
    .y_i     (den_fix),
    .done_o  (red_done),
    .qx_o    (qx),
    .qy_o    (qy)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign div_error_o = err_q;

`ifndef ASSERT_OFF
  a_den_zero_iff_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ((res_den_o == '0) == div_error_o))
    else $error("denominator zero does not match error flag");
  a_err_num_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && div_error_o) |-> (res_num_o == '0))
    else $error("error result has nonzero numerator");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("start transfer did not raise busy");
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");
`endif
endmodule
